[design/sti_pkg.sv]
package sti_pkg;

	// Fixed field widths of the command channel and the configuration port.
	localparam int CMD_W      = 3;
	localparam int POS_Y_W    = 7;
	localparam int POS_Z_W    = 5;
	localparam int FRAC_IN_W  = 16;
	localparam int CELLS_XZ_W = 5;
	localparam int CELLS_Y_W  = 7;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SELECT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LERP_Y = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LERP_X = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LERP_Z = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd5;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_XZ = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y  = 1'b1;

	localparam logic [CELLS_XZ_W-1:0] CELLS_XZ_RST = 5'd4;
	localparam logic [CELLS_Y_W-1:0]  CELLS_Y_RST  = 7'd48;

endpackage

[design/sliced_trilinear_interpolator_core.sv]
// Channel    | Ports                                              | Handshake
// -----------+----------------------------------------------------+---------------------------
// command    | cmd, slice_sel, pos_y, pos_z, noise_in, frac       | start high, busy low
// result     | value_out, range_error                             | done high for one cycle
// config     | cfg_index, cfg_wdata                               | cfg_we high, no wait
//
// Each command transaction yields one result transaction. A write, a swap, a spare code or a
// rejected select goes from idle straight to the result state. A cell select makes four reads on
// one port per slice memory, waits for the registered data, then gives the result. A lerp feeds
// four pairs along y, two along x or one along z to one shared multiplier, one pair per cycle,
// with a register between the product and the final add. Reset sets all but the slice memories
// (empty until written), their read registers and the lerp data registers. No result stalls.
module sliced_trilinear_interpolator_core #(
	parameter int MAX_CELLS_XZ = 16,
	parameter int MAX_CELLS_Y  = 64,
	parameter int VALUE_BITS   = 32,
	parameter int FRAC_BITS    = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Command channel.
	input  logic                                  start,
	output logic                                  busy,
	input  logic [sti_pkg::CMD_W-1:0]             cmd,
	input  logic                                  slice_sel,
	input  logic [sti_pkg::POS_Y_W-1:0]           pos_y,
	input  logic [sti_pkg::POS_Z_W-1:0]           pos_z,
	input  logic signed [VALUE_BITS-1:0]          noise_in,
	input  logic [sti_pkg::FRAC_IN_W-1:0]         frac,
	// Result channel.
	output logic                                  done,
	output logic signed [VALUE_BITS-1:0]          value_out,
	output logic                                  range_error,
	// Configuration port.
	input  logic                                  cfg_we,
	input  logic [sti_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sti_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	import sti_pkg::*;

	// Each slice is laid out row by row with a fixed stride, whatever the configured width.
	localparam int ROW_LEN  = MAX_CELLS_XZ + 1;
	localparam int BANK_LEN = ROW_LEN * (MAX_CELLS_Y + 1);
	localparam int AW       = $clog2(BANK_LEN);
	localparam int PW       = VALUE_BITS + FRAC_BITS + 2;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_LERP = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	state_t                    state_q;
	logic [2:0]                cnt_q;
	logic [CMD_W-1:0]          cmd_q;
	logic [FRAC_BITS-1:0]      t_q;
	logic [AW-1:0]             base_q;
	logic [POS_Z_W-1:0]        z_q;
	logic                      err_q;
	logic                      front_is_b_q;
	logic [CELLS_XZ_W-1:0]     cells_xz_q;
	logic [CELLS_Y_W-1:0]      cells_y_q;

	logic signed [VALUE_BITS-1:0] corner_q [8];
	logic signed [VALUE_BITS-1:0] yp_q [4];
	logic signed [VALUE_BITS-1:0] xp_q [2];
	logic signed [VALUE_BITS-1:0] final_q;

	// The two slice memories are physical banks A and B; front_is_b_q picks the roles.
	logic signed [VALUE_BITS-1:0] mem_a [BANK_LEN];
	logic signed [VALUE_BITS-1:0] mem_b [BANK_LEN];
	logic signed [VALUE_BITS-1:0] rd_a_q;
	logic signed [VALUE_BITS-1:0] rd_b_q;

	// Lerp pipeline registers.
	logic signed [PW-1:0]         prod_s1;
	logic signed [VALUE_BITS-1:0] a_s1;
	logic [1:0]                   idx_s1;
	logic                         vld_s1;

	logic                  accept;
	logic [CELLS_XZ_W-1:0] nxz;
	logic [CELLS_Y_W-1:0]  ny;
	logic                  wr_err;
	logic                  sel_err;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr;
	logic                  wr_en;
	logic                  wr_bank;
	logic [2:0]            n_lerp;
	logic signed [VALUE_BITS-1:0] lerp_a;
	logic signed [VALUE_BITS-1:0] lerp_b;
	logic signed [VALUE_BITS:0]   lerp_d;
	logic signed [PW-1:0]         prod_shift;
	logic signed [VALUE_BITS-1:0] lerp_res;
	logic [1:0]                   cap_k;
	logic signed [VALUE_BITS-1:0] rd_front;
	logic signed [VALUE_BITS-1:0] rd_back;

	assign accept      = start && (state_q == ST_IDLE);
	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_RESP);
	assign value_out   = final_q;
	assign range_error = err_q;

	// A register value above the built-in maximum acts as that maximum.
	assign nxz = (32'(cells_xz_q) > 32'(MAX_CELLS_XZ)) ? CELLS_XZ_W'(MAX_CELLS_XZ) : cells_xz_q;
	assign ny  = (32'(cells_y_q) > 32'(MAX_CELLS_Y)) ? CELLS_Y_W'(MAX_CELLS_Y) : cells_y_q;

	// A write may touch the far edge of the lattice; a select needs one more entry along each axis.
	assign wr_err  = (pos_y > ny) || (pos_z > nxz);
	assign sel_err = (pos_y >= ny) || (pos_z >= nxz);

	assign waddr   = AW'(32'(pos_y) * ROW_LEN + 32'(pos_z));
	assign wr_en   = accept && (cmd == CMD_WRITE) && !wr_err;
	assign wr_bank = front_is_b_q ^ slice_sel;

	// Read k of a select fetches the corner at row offset k[1] and column offset k[0].
	assign raddr = base_q + (cnt_q[1] ? AW'(ROW_LEN) : AW'(0)) + AW'(z_q) + AW'(cnt_q[0]);

	assign cap_k    = 2'(cnt_q - 3'd1);
	assign rd_front = front_is_b_q ? rd_b_q : rd_a_q;
	assign rd_back  = front_is_b_q ? rd_a_q : rd_b_q;

	// Pair selection for the shared lerp unit. Corner index bits are x, y, z from the top.
	always_comb begin
		n_lerp = 3'd1;
		lerp_a = xp_q[0];
		lerp_b = xp_q[1];
		case (cmd_q)
			CMD_LERP_Y: begin
				n_lerp = 3'd4;
				lerp_a = corner_q[{cnt_q[1], 1'b0, cnt_q[0]}];
				lerp_b = corner_q[{cnt_q[1], 1'b1, cnt_q[0]}];
			end
			CMD_LERP_X: begin
				n_lerp = 3'd2;
				lerp_a = yp_q[{1'b0, cnt_q[0]}];
				lerp_b = yp_q[{1'b1, cnt_q[0]}];
			end
			default: begin
				n_lerp = 3'd1;
			end
		endcase
	end

	// The arithmetic shift floors the scaled product; the result always lies between a and b,
	// so keeping the low bits of the sum is exact.
	assign lerp_d     = {lerp_b[VALUE_BITS-1], lerp_b} - {lerp_a[VALUE_BITS-1], lerp_a};
	assign prod_shift = prod_s1 >>> FRAC_BITS;
	assign lerp_res   = a_s1 + prod_shift[VALUE_BITS-1:0];

	always_ff @(posedge clk) begin
		if (wr_en && !wr_bank) begin
			mem_a[waddr] <= noise_in;
		end
		rd_a_q <= mem_a[raddr];
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_bank) begin
			mem_b[waddr] <= noise_in;
		end
		rd_b_q <= mem_b[raddr];
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(lerp_d * $signed({1'b0, t_q}));
		a_s1    <= lerp_a;
		idx_s1  <= cnt_q[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			cmd_q        <= CMD_WRITE;
			t_q          <= '0;
			base_q       <= '0;
			z_q          <= '0;
			err_q        <= 1'b0;
			front_is_b_q <= 1'b0;
			cells_xz_q   <= CELLS_XZ_RST;
			cells_y_q    <= CELLS_Y_RST;
			vld_s1       <= 1'b0;
			final_q      <= '0;
			for (int i = 0; i < 8; i++) begin
				corner_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				yp_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				xp_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CELLS_XZ: cells_xz_q <= cfg_wdata[CELLS_XZ_W-1:0];
					CFG_CELLS_Y:  cells_y_q  <= cfg_wdata[CELLS_Y_W-1:0];
					default: ;
				endcase
			end

			vld_s1 <= (state_q == ST_LERP) && (cnt_q < n_lerp);
			if (vld_s1) begin
				case (cmd_q)
					CMD_LERP_Y: yp_q[idx_s1]    <= lerp_res;
					CMD_LERP_X: xp_q[idx_s1[0]] <= lerp_res;
					CMD_LERP_Z: final_q         <= lerp_res;
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q  <= cmd;
						t_q    <= FRAC_BITS'(frac);
						base_q <= AW'(32'(pos_y) * ROW_LEN);
						z_q    <= pos_z;
						cnt_q  <= '0;
						case (cmd)
							CMD_WRITE: begin
								err_q   <= wr_err;
								state_q <= ST_RESP;
							end
							CMD_SELECT: begin
								err_q   <= sel_err;
								state_q <= sel_err ? ST_RESP : ST_READ;
							end
							CMD_LERP_Y, CMD_LERP_X, CMD_LERP_Z: begin
								err_q   <= 1'b0;
								state_q <= ST_LERP;
							end
							CMD_SWAP: begin
								err_q        <= 1'b0;
								state_q      <= ST_RESP;
								front_is_b_q <= !front_is_b_q;
							end
							default: begin
								err_q   <= 1'b0;
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_READ: begin
					// Reads go out on counts 0 to 3; the registered data for read k is captured at count k+1.
					if (cnt_q != 3'd0) begin
						corner_q[{1'b0, cap_k}] <= rd_front;
						corner_q[{1'b1, cap_k}] <= rd_back;
					end
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= ST_RESP;
					end
				end
				ST_LERP: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == n_lerp) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/sti_chk.sv]
module sti_chk #(
	parameter int VALUE_BITS = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [sti_pkg::CMD_W-1:0]    cmd,
	input logic                         done,
	input logic signed [VALUE_BITS-1:0] value_out,
	input logic                         range_error
);
	import sti_pkg::*;

	// An accepted transaction keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after an accepted transaction");

	// A result is only shown while busy, and the block is idle right after it.
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy)
		else $error("result not followed by idle");

	// A swap answers in the next cycle and never reports a range error.
	a_swap_resp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_SWAP |=> done && !range_error)
		else $error("swap result wrong");

	// A write answers in the next cycle and leaves the interpolated value alone.
	a_write_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_WRITE |=> done && $stable(value_out))
		else $error("write changed the value or gave no result");

endmodule

bind sliced_trilinear_interpolator_core sti_chk #(.VALUE_BITS(VALUE_BITS)) u_sti_chk (.*);
